// ----- rtl/core/mmsp_pkg.sv -----
// package for the multi-motor speed regulator: widths, reset values,
// register map, state encoding and the per-motor entry layout
// no dependencies
package mmsp_pkg;

    // motor count default and field widths
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int CAP_W           = 16;
    localparam int MIDX_IN_W       = 2;
    localparam int SPEED_W         = 12;
    localparam int DRIVE_W         = 11;
    localparam int TARGET_W        = 12;
    localparam int GAIN_W          = 8;
    localparam int LIM_W           = 10;
    localparam int ERR_W           = 13;
    localparam int PREV_W          = 14;
    localparam int INTEG_W         = 16;
    localparam int DIFF_W          = 15;
    localparam int PROD_W          = 24;
    localparam int DRV_SUM_W       = 26;

    // speed = SPEED_NUM / (period * PERIOD_SCALE); the nested floor lets the
    // scale fold into the numerator, so only a small quotient is iterated
    localparam int SPEED_NUM      = 2000000;
    localparam int PERIOD_SCALE   = 990;
    localparam int SPEED_DIVIDEND = SPEED_NUM / PERIOD_SCALE;
    localparam int DVD_W          = $clog2(SPEED_DIVIDEND + 1);
    localparam int DIV_CNT_W      = $clog2(DVD_W);

    // register reset values
    localparam logic signed [TARGET_W-1:0] TARGET_RST = 12'sd1;
    localparam logic [GAIN_W-1:0]          GAIN_P_RST = 8'd150;
    localparam logic [GAIN_W-1:0]          GAIN_I_RST = 8'd2;
    localparam logic [GAIN_W-1:0]          GAIN_D_RST = 8'd7;
    localparam logic [LIM_W-1:0]           LIM_RST    = 10'd1023;

    // integral saturation bounds
    localparam int INTEG_MAX = 32767;
    localparam int INTEG_MIN = -32768;

    // config port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_GAIN_P = 3'd1,
        REG_GAIN_I = 3'd2,
        REG_GAIN_D = 3'd3,
        REG_LIMIT  = 3'd4
    } t_reg_idx;

    // operation codes of an input word
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EDGE,
        S_START,
        S_DIV,
        S_ERR,
        S_MULP,
        S_MULI,
        S_MULD,
        S_INT,
        S_SUM,
        S_DONE
    } t_state;

    // one memory row per motor
    typedef struct packed {
        logic [CAP_W-1:0]          last_cap;
        logic [CAP_W-1:0]          period;
        logic                      fwd;
        logic signed [INTEG_W-1:0] integ;
        logic signed [PREV_W-1:0]  prev_err;
    } t_entry;

endpackage

// ----- rtl/core/mmsp_if.sv -----
// valid/ready channel interfaces for input words and result words
// depends on mmsp_pkg for field widths
interface mmsp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [mmsp_pkg::MIDX_IN_W-1:0]   motor_index;
    logic [mmsp_pkg::CAP_W-1:0]       capture_value;
    logic                             direction_high;

    modport source (output valid, operation, motor_index, capture_value, direction_high,
                    input ready);
    modport sink   (input valid, operation, motor_index, capture_value, direction_high,
                    output ready);
endinterface

interface mmsp_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [mmsp_pkg::MIDX_IN_W-1:0]        served_motor;
    logic signed [mmsp_pkg::SPEED_W-1:0]   measured_speed;
    logic signed [mmsp_pkg::DRIVE_W-1:0]   drive_value;

    modport source (output valid, served_motor, measured_speed, drive_value, input ready);
    modport sink   (input valid, served_motor, measured_speed, drive_value, output ready);
endinterface

// ----- rtl/core/mmsp_div.sv -----
// serial restoring divider: fixed speed numerator over the encoder period,
// one quotient bit per cycle; depends on mmsp_pkg
module mmsp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mmsp_pkg::CAP_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [mmsp_pkg::DVD_W-1:0]   o_quot
);
    import mmsp_pkg::*;

    localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(SPEED_DIVIDEND);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CAP_W-1:0]     r_div;
    logic [CAP_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVD_W-1:0]     r_quot;

    logic [CAP_W:0]       w_trial;
    logic                 w_fit;
    logic [CAP_W:0]       w_diff;

    // trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, remainder below the divisor whenever the divisor is nonzero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_dvd  <= DIVIDEND;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[CAP_W-1:0] : w_trial[CAP_W-1:0];
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[DVD_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/multi_motor_speed_pid_top.sv -----
// multi-motor speed regulator: edge words update a motor's row, tick words
// run one pid step for the next motor in turn
// an edge word runs idle, read, edge (row written); a tick word runs idle, read, start,
// divide (11 quotient bits, then done), err, mulp, muli, muld, int, sum and done, where
// it waits for a free result register; words are taken only in idle, one at a time
// reset: synchronous active low; rows read as zero until written, registers to defaults
module multi_motor_speed_pid_top #(
    parameter int MOTOR_COUNT = mmsp_pkg::MOTOR_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mmsp_in_if.sink                          i_item,
    mmsp_out_if.source                       o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mmsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mmsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mmsp_pkg::*;

    localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    // config registers
    logic signed [TARGET_W-1:0] r_target;
    logic [GAIN_W-1:0]          r_gain_p;
    logic [GAIN_W-1:0]          r_gain_i;
    logic [GAIN_W-1:0]          r_gain_d;
    logic [LIM_W-1:0]           r_lim;
    logic                       w_cfg_wr;

    // control
    t_state                     r_state;
    t_state                     n_state;
    logic                       w_in_acc;
    logic                       w_rd_en;
    logic                       w_mem_we;
    logic                       w_div_start;
    logic                       w_out_load;
    logic                       w_out_free;
    logic                       w_div_done;
    logic [DVD_W-1:0]           w_quot;

    // captured word
    logic                       r_op;
    logic                       r_ok;
    logic [CAP_W-1:0]           r_cap;
    logic                       r_dir;
    logic [MIDX_W-1:0]          r_addr;
    logic [MIDX_W-1:0]          r_ptr;
    logic [MIDX_W-1:0]          w_ptr_next;
    logic [15:0]                w_idx16;
    logic [15:0]                w_addr16;

    // state memory with per-row valid bits
    t_entry                     r_mem [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]     r_vld;
    t_entry                     r_rd;
    logic                       r_rd_vld;
    t_entry                     w_ent;
    t_entry                     n_entry;

    // pid datapath
    logic signed [SPEED_W-1:0]   w_speed;
    logic signed [SPEED_W-1:0]   r_speed;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [DIFF_W-1:0]    w_err15;
    logic signed [DIFF_W-1:0]    r_diff;
    logic signed [DIFF_W-1:0]    w_mul_a;
    logic signed [GAIN_W:0]      w_mul_b;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [PROD_W-1:0]    r_prod_p;
    logic signed [PROD_W-1:0]    r_prod_i;
    logic signed [PROD_W-1:0]    r_prod_d;
    logic signed [PROD_W:0]      w_isum;
    logic signed [INTEG_W-1:0]   r_integ;
    logic signed [DRV_SUM_W-1:0] r_drive;
    logic signed [DRV_SUM_W-1:0] w_lim26;
    logic signed [DRV_SUM_W-1:0] w_clamp;

    // output register
    logic                        r_out_valid;
    logic [MIDX_IN_W-1:0]        r_out_motor;
    logic signed [SPEED_W-1:0]   r_out_speed;
    logic signed [DRIVE_W-1:0]   r_out_drive;

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_gain_p <= GAIN_P_RST;
            r_gain_i <= GAIN_I_RST;
            r_gain_d <= GAIN_D_RST;
            r_lim    <= LIM_RST;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
                REG_TARGET: r_target <= $signed(pwdata[TARGET_W-1:0]);
                REG_GAIN_P: r_gain_p <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: r_gain_i <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: r_gain_d <= pwdata[GAIN_W-1:0];
                REG_LIMIT:  r_lim    <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
            REG_TARGET: prdata = {{(APB_DATA_W-TARGET_W){r_target[TARGET_W-1]}}, r_target};
            REG_GAIN_P: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_gain_p};
            REG_GAIN_I: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_gain_i};
            REG_GAIN_D: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_gain_d};
            REG_LIMIT:  prdata = {{(APB_DATA_W-LIM_W){1'b0}}, r_lim};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_READ;
            S_READ:  n_state = (r_op == OP_TICK) ? S_START : S_EDGE;
            S_EDGE:  n_state = S_IDLE;
            S_START: n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_ERR;
            S_ERR:   n_state = S_MULP;
            S_MULP:  n_state = S_MULI;
            S_MULI:  n_state = S_MULD;
            S_MULD:  n_state = S_INT;
            S_INT:   n_state = S_SUM;
            S_SUM:   n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs; the write-back always lands before the next read is
    // issued, so accesses to one row never overlap
    always_comb begin
        i_item.ready = 1'b0;
        w_rd_en      = 1'b0;
        w_mem_we     = 1'b0;
        w_div_start  = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  i_item.ready = 1'b1;
            S_READ:  w_rd_en      = 1'b1;
            S_EDGE:  w_mem_we     = r_ok;
            S_START: w_div_start  = 1'b1;
            S_DONE: begin
                w_mem_we   = w_out_free;
                w_out_load = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- word capture and motor pointer ----------------
    assign w_ptr_next = (r_ptr == MIDX_W'(MOTOR_COUNT - 1)) ? '0 : r_ptr + 1'b1;
    assign w_idx16    = 16'(i_item.motor_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (w_in_acc && i_item.operation == OP_TICK) begin
            r_ptr <= w_ptr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= i_item.operation;
            r_cap  <= i_item.capture_value;
            r_dir  <= i_item.direction_high;
            r_ok   <= int'(i_item.motor_index) < MOTOR_COUNT;
            r_addr <= (i_item.operation == OP_TICK) ? w_ptr_next : w_idx16[MIDX_W-1:0];
        end
    end

    // ---------------- state memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_addr] <= n_entry;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_vld[r_addr];
            end
        end
    end

    // a row never written reads as zero
    assign w_ent = r_rd_vld ? r_rd : '0;

    // row update for an edge or for a finished tick
    always_comb begin
        n_entry = w_ent;
        if (r_op == OP_EDGE) begin
            n_entry.fwd      = r_dir;
            n_entry.last_cap = r_cap;
            if (r_cap != w_ent.last_cap) begin
                n_entry.period = r_cap - w_ent.last_cap;
            end
        end else begin
            n_entry.integ    = r_integ;
            n_entry.prev_err = {r_err[ERR_W-1], r_err};
        end
    end

    // ---------------- speed ----------------
    mmsp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_ent.period),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // signed speed, zero period means standstill
    always_comb begin
        if (w_ent.period == '0) begin
            w_speed = '0;
        end else if (w_ent.fwd) begin
            w_speed = $signed({1'b0, w_quot});
        end else begin
            w_speed = -$signed({1'b0, w_quot});
        end
    end

    // ---------------- pid ----------------
    assign w_err15 = {{(DIFF_W-ERR_W){r_err[ERR_W-1]}}, r_err};

    // one shared multiplier, operands picked by step
    always_comb begin
        case (r_state)
            S_MULI:  w_mul_b = $signed({1'b0, r_gain_i});
            S_MULD:  w_mul_b = $signed({1'b0, r_gain_d});
            default: w_mul_b = $signed({1'b0, r_gain_p});
        endcase
        w_mul_a = (r_state == S_MULD) ? r_diff : w_err15;
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_isum = {{(PROD_W+1-INTEG_W){w_ent.integ[INTEG_W-1]}}, w_ent.integ}
                  + {r_prod_i[PROD_W-1], r_prod_i};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_ERR: begin
                r_speed <= w_speed;
                r_err   <= {r_target[TARGET_W-1], r_target} - {w_speed[SPEED_W-1], w_speed};
            end
            S_MULP: begin
                r_prod_p <= w_prod;
                r_diff   <= w_err15 - {w_ent.prev_err[PREV_W-1], w_ent.prev_err};
            end
            S_MULI: r_prod_i <= w_prod;
            S_MULD: r_prod_d <= w_prod;
            S_INT: begin
                // saturate the accumulator to 16 bits
                if (w_isum > (PROD_W+1)'(INTEG_MAX)) begin
                    r_integ <= INTEG_W'(INTEG_MAX);
                end else if (w_isum < (PROD_W+1)'(INTEG_MIN)) begin
                    r_integ <= INTEG_W'(INTEG_MIN);
                end else begin
                    r_integ <= w_isum[INTEG_W-1:0];
                end
            end
            S_SUM: begin
                r_drive <= {{(DRV_SUM_W-PROD_W){r_prod_p[PROD_W-1]}}, r_prod_p}
                         + {{(DRV_SUM_W-PROD_W){r_prod_d[PROD_W-1]}}, r_prod_d}
                         + {{(DRV_SUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ};
            end
            default: ;
        endcase
    end

    // symmetric clamp
    assign w_lim26 = $signed({{(DRV_SUM_W-LIM_W){1'b0}}, r_lim});
    always_comb begin
        if (r_drive > w_lim26) begin
            w_clamp = w_lim26;
        end else if (r_drive < -w_lim26) begin
            w_clamp = -w_lim26;
        end else begin
            w_clamp = r_drive;
        end
    end

    // ---------------- result register ----------------
    assign w_addr16 = 16'(r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_motor <= w_addr16[MIDX_IN_W-1:0];
            r_out_speed <= r_speed;
            r_out_drive <= w_clamp[DRIVE_W-1:0];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.served_motor   = r_out_motor;
    assign o_result.measured_speed = r_out_speed;
    assign o_result.drive_value    = r_out_drive;

    // ---------------- checks ----------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared without a finished tick");

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_drive <= $signed({1'b0, r_lim}))
                        && (r_out_drive >= -$signed({1'b0, r_lim})))
        else $error("drive word outside the limit");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ptr) < MOTOR_COUNT)
        else $error("motor pointer out of range");

endmodule

// ----- tb/multi_motor_speed_pid_top_tb.sv -----
// testbench for the multi-motor speed regulator: drives edge and tick words,
// predicts each tick's served motor, speed and drive, and checks every result word
// depends on mmsp_pkg, mmsp_in_if, mmsp_out_if and multi_motor_speed_pid_top
module multi_motor_speed_pid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmsp_pkg::*;

    localparam int MOTORS = MOTOR_COUNT_DEF;
    localparam int SETTLE = 40;

    typedef struct packed {
        logic                 op;
        logic [MIDX_IN_W-1:0] motor;
        logic [CAP_W-1:0]     cap;
        logic                 dir;
    } t_motor_word;

    typedef struct packed {
        logic [MIDX_IN_W-1:0]       motor;
        logic signed [SPEED_W-1:0]  speed;
        logic signed [DRIVE_W-1:0]  drive;
    } t_drive_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // config port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mmsp_in_if  in_ch ();
    mmsp_out_if out_ch ();

    multi_motor_speed_pid_top #(.MOTOR_COUNT(MOTORS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // words waiting to be sent and drive results waiting to arrive
    t_motor_word   word_pending_q[$];
    t_drive_result drive_expect_q[$];

    int err_cnt       = 0;
    int words_sent    = 0;
    int ticks_checked = 0;
    int settings_used = 1;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // regulator copy: registers and per-motor state
    int cfg_target = 1;
    int cfg_gain_p = 150;
    int cfg_gain_i = 2;
    int cfg_gain_d = 7;
    int cfg_limit  = 1023;

    logic [CAP_W-1:0] mot_last_cap [MOTORS];
    logic [CAP_W-1:0] mot_period   [MOTORS];
    logic             mot_fwd      [MOTORS];
    int               mot_integ    [MOTORS];
    int               mot_prev_err [MOTORS];
    int               tick_ptr;

    // stimulus side: running capture per motor and preferred direction
    logic [CAP_W-1:0] cap_cursor [4];
    logic             dir_pref   [4];

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_EDGE;
        in_ch.motor_index    = '0;
        in_ch.capture_value  = '0;
        in_ch.direction_high = 1'b0;
        out_ch.ready         = 1'b0;
        tick_ptr             = 0;
        for (int k = 0; k < MOTORS; k++) begin
            mot_last_cap[k] = '0;
            mot_period[k]   = '0;
            mot_fwd[k]      = 1'b0;
            mot_integ[k]    = 0;
            mot_prev_err[k] = 0;
        end
        for (int k = 0; k < 4; k++) begin
            cap_cursor[k] = '0;
            dir_pref[k]   = 1'b1;
        end
    end

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicts the effect of one accepted word; ticks queue a drive result
    function automatic void predict_drive(t_motor_word w);
        int m;
        int spd;
        int err;
        int integ;
        int drv;
        t_drive_result r;
        if (w.op == OP_EDGE) begin
            m = int'(w.motor);
            if (m >= MOTORS) return;
            mot_fwd[m] = w.dir;
            // equal captures keep the old period; the difference wraps mod 2^16
            if (w.cap != mot_last_cap[m]) mot_period[m] = w.cap - mot_last_cap[m];
            mot_last_cap[m] = w.cap;
        end else begin
            tick_ptr = (tick_ptr + 1) % MOTORS;
            m = tick_ptr;
            spd = 0;
            if (mot_period[m] != '0) begin
                spd = SPEED_NUM / (int'(mot_period[m]) * PERIOD_SCALE);
                if (!mot_fwd[m]) spd = -spd;
            end
            err = cfg_target - spd;
            integ = mot_integ[m] + cfg_gain_i * err;
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            if (integ < INTEG_MIN) integ = INTEG_MIN;
            mot_integ[m] = integ;
            drv = cfg_gain_p * err + (err - mot_prev_err[m]) * cfg_gain_d + integ;
            mot_prev_err[m] = err;
            if (drv > cfg_limit) drv = cfg_limit;
            if (drv < -cfg_limit) drv = -cfg_limit;
            r.motor = MIDX_IN_W'(m);
            r.speed = SPEED_W'(spd);
            r.drive = DRIVE_W'(drv);
            drive_expect_q.push_back(r);
        end
    endfunction

    // word driver: holds a presented word until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_drive(word_pending_q.pop_front());
                words_sent++;
            end
            if (word_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid          <= 1'b1;
                in_ch.operation      <= word_pending_q[0].op;
                in_ch.motor_index    <= word_pending_q[0].motor;
                in_ch.capture_value  <= word_pending_q[0].cap;
                in_ch.direction_high <= word_pending_q[0].dir;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: compares each word with the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_drive_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("result word with nothing expected: motor %0d speed %0d drive %0d",
                           out_ch.served_motor, out_ch.measured_speed, out_ch.drive_value);
                    err_cnt++;
                end else begin
                    want = drive_expect_q.pop_front();
                    ticks_checked++;
                    if (out_ch.served_motor !== want.motor) begin
                        $error("served_motor: expected %0d, got %0d",
                               want.motor, out_ch.served_motor);
                        err_cnt++;
                    end
                    if (out_ch.measured_speed !== want.speed) begin
                        $error("measured_speed: expected %0d, got %0d",
                               want.speed, out_ch.measured_speed);
                        err_cnt++;
                    end
                    if (out_ch.drive_value !== want.drive) begin
                        $error("drive_value: expected %0d, got %0d",
                               want.drive, out_ch.drive_value);
                        err_cnt++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // waits until every word is sent and every result has come, then settles
    task automatic wait_idle(int settle);
        while (word_pending_q.size() != 0 || drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // one register write: setup cycle, then access until pready
    task automatic write_reg(t_reg_idx idx, int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(int target, int gp, int gi, int gd, int lim);
        write_reg(REG_TARGET, target);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_LIMIT, lim);
        cfg_target = target;
        cfg_gain_p = gp;
        cfg_gain_i = gi;
        cfg_gain_d = gd;
        cfg_limit  = lim;
        settings_used++;
    endtask

    task automatic push_edge(int m, int cap, bit dir);
        t_motor_word w;
        w.op    = OP_EDGE;
        w.motor = MIDX_IN_W'(m);
        w.cap   = CAP_W'(cap);
        w.dir   = dir;
        word_pending_q.push_back(w);
    endtask

    task automatic push_ticks(int n);
        t_motor_word w;
        for (int k = 0; k < n; k++) begin
            w.op    = OP_TICK;
            w.motor = MIDX_IN_W'($urandom_range(3));
            w.cap   = CAP_W'($urandom);
            w.dir   = 1'($urandom_range(1));
            word_pending_q.push_back(w);
        end
    endtask

    // mostly plausible encoder streams per motor, with some noise mixed in
    function automatic t_motor_word rand_word();
        t_motor_word w;
        int          m;
        int          sel;
        logic [CAP_W-1:0] step;
        m     = $urandom_range(3);
        w.motor = MIDX_IN_W'(m);
        if ($urandom_range(99) < 40) begin
            w.op  = OP_TICK;
            w.cap = CAP_W'($urandom);
            w.dir = 1'($urandom_range(1));
            return w;
        end
        w.op = OP_EDGE;
        sel  = $urandom_range(99);
        if (sel < 60)      step = CAP_W'($urandom_range(1, 40));
        else if (sel < 75) step = CAP_W'($urandom_range(41, 3000));
        else if (sel < 85) step = '0;
        else               step = CAP_W'($urandom);
        cap_cursor[m] = cap_cursor[m] + step;
        if ($urandom_range(99) < 5) dir_pref[m] = ~dir_pref[m];
        w.cap = cap_cursor[m];
        w.dir = ($urandom_range(99) < 10) ? ~dir_pref[m] : dir_pref[m];
        return w;
    endfunction

    // stimulus
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero period first, then equal captures, fastest and
        // slowest periods, timer wrap and a direction change with no new period
        push_ticks(1);
        push_edge(0, 0, 1'b1);
        push_edge(1, 1, 1'b1);
        push_edge(2, 16'hFFFF, 1'b0);
        push_edge(2, 1, 1'b0);
        push_edge(3, 16'h8000, 1'b1);
        push_edge(3, 16'h8003, 1'b1);
        push_edge(1, 1, 1'b0);
        push_ticks(4);

        // integral saturation both ways and drive clamp at full limit
        wait_idle(SETTLE);
        set_regs(2047, 255, 255, 255, 1023);
        push_ticks(4);
        wait_idle(SETTLE);
        set_regs(-2048, 255, 255, 255, 1023);
        push_ticks(4);

        // random phases over register settings and flow-control patterns
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle(SETTLE);
            case (ph)
                0: set_regs(1, 150, 2, 7, 1023);
                1: set_regs(2047, 255, 255, 255, 1023);
                2: set_regs(-2048, 0, 0, 0, 0);
                4: set_regs(0, 1, 1, 1, 1);
                default: set_regs(int'($urandom_range(4095)) - 2048, $urandom_range(255),
                                  $urandom_range(255), $urandom_range(255),
                                  $urandom_range(1023));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (int k = 0; k < 125; k++) begin
                // sender holds off mid-phase until all drive results are back
                if (k == 62) wait_idle(0);
                word_pending_q.push_back(rand_word());
            end
        end

        wait_idle(SETTLE);
        $display("sent %0d words, checked %0d drive results across %0d register settings",
                 words_sent, ticks_checked, settings_used);
        $display("flow control covered free running, sender gaps, receiver stalls and both");
        if (err_cnt == 0 && drive_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- multi_motor_speed_pid_top.f -----
rtl/core/mmsp_pkg.sv
rtl/core/mmsp_if.sv
rtl/core/mmsp_div.sv
rtl/core/multi_motor_speed_pid_top.sv
tb/multi_motor_speed_pid_top_tb.sv
